### sv/qwdp_pkg.sv
// Package for the quantized weight dot product block.
// Payload structs, FP constants and the FP16 to FP32 converter; no dependencies.
`default_nettype none
package qwdp_pkg;

  localparam int QueueDepth = 2;
  localparam logic [31:0] CanonNan = 32'h7FC0_0000;

  typedef struct packed {
    logic [7:0]  weight_byte;
    logic        nibble_select;
    logic [15:0] scale_half;
    logic [31:0] activation_bits;
    logic        row_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] weight_value;
    logic [31:0] row_sum;
    logic        row_done;
  } out_item_t;

  // Classified item handed from front to back.
  typedef struct packed {
    logic [31:0] qval;
    logic [31:0] scale;
    logic [31:0] act;
    logic        row_end;
  } work_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_W, ST_MUL_P, ST_ADD, ST_OUT
  } back_state_t;

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0] ex;
    logic [9:0] man;
    logic [7:0] e32;
    logic [3:0] lz;
    logic [10:0] sh;
    begin
      ex  = h[14:10];
      man = h[9:0];
      lz  = 4'd0;
      for (int i = 9; i >= 0; i--) begin
        if (man[i] && lz == 4'd0) lz = 4'(10 - i);
      end
      sh = {1'b0, man} << lz;
      e32 = 8'd113 - 8'(lz);
      if (ex == 5'd0) begin
        if (man == 10'd0) half_to_single = {h[15], 31'd0};
        else half_to_single = {h[15], e32, sh[9:0], 13'd0};
      end else if (ex == 5'd31) begin
        half_to_single = {h[15], 8'hFF, man, 13'd0};
      end else begin
        half_to_single = {h[15], 8'(ex) + 8'd112, man, 13'd0};
      end
    end
  endfunction

  // Exact small integer to FP32 (|v| <= 128).
  function automatic logic [31:0] int_to_single(input logic signed [8:0] v);
    logic [7:0] m;
    logic [2:0] p;
    logic [22:0] f;
    begin
      m = v[8] ? 8'(-v) : v[7:0];
      p = 3'd0;
      for (int i = 0; i < 8; i++) begin
        if (m[i]) p = 3'(i);
      end
      f = 23'({m, 15'd0} << (3'd7 - p)) ;
      f = {f[21:0], 1'b0};
      if (m == 8'd0) int_to_single = 32'd0;
      else int_to_single = {v[8], 8'd127 + 8'(p), f};
    end
  endfunction

endpackage
`default_nettype wire

### sv/qwdp_fmul.sv
// FP32 multiplier, round to nearest even, subnormals, canonical NaN.
// Two register stages: mantissa product, then normalize and round. Uses qwdp_pkg.
`default_nettype none
module qwdp_fmul
  import qwdp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic [31:0]      y
);
  logic        s1, spec1;
  logic [31:0] spec_val1;
  logic signed [10:0] e1;
  logic [47:0] p1;

  logic [23:0] ma, mb;
  logic signed [10:0] ea, eb;
  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

  always_comb begin
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = a[30:0] == 31'd0;
    b_zero = b[30:0] == 31'd0;
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    ea = (a[30:23] == 8'd0) ? 11'sd1 : 11'(a[30:23]);
    eb = (b[30:23] == 8'd0) ? 11'sd1 : 11'(b[30:23]);
  end

  always_ff @(posedge clk) begin
    s1 <= a[31] ^ b[31];
    p1 <= ma * mb;
    e1 <= ea + eb - 11'sd127;
    spec1 <= a_nan || b_nan || a_inf || b_inf || a_zero || b_zero;
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
      spec_val1 <= CanonNan;
    else if (a_inf || b_inf)
      spec_val1 <= {a[31] ^ b[31], 8'hFF, 23'd0};
    else
      spec_val1 <= {a[31] ^ b[31], 31'd0};
  end

  // Product value = p1 * 2^(e1-127-46); leading one at bit 47 or 46 or lower.
  logic [5:0]  lz;
  logic signed [11:0] e_n;
  logic [47:0] pn;
  logic [72:0] wide;
  logic [23:0] mant;
  logic g, st;
  logic [24:0] rnd;
  logic signed [11:0] e_f;
  logic [31:0] res;
  int sh;

  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (p1[i]) lz = 6'(47 - i);
    end
    // exponent when leading one moved to bit 47
    e_n = 12'(e1) + 12'sd1 - 12'(lz);
    if (e_n >= 12'sd1) sh = int'(lz);
    else sh = int'(lz) + int'(e_n) - 1;
    wide = {p1, 25'd0};
    if (sh >= 0) wide = wide << sh;
    else wide = wide >> (-sh);
    mant = wide[72:49];
    g  = wide[48];
    st = wide[47:0] != 48'd0;
    rnd = {1'b0, mant} + 25'(g && (st || mant[0]));
    e_f = (e_n >= 12'sd1) ? e_n : 12'sd0;
    if (rnd[24]) begin
      e_f = e_f + 12'sd1;
      rnd = rnd >> 1;
    end else if (e_f == 12'sd0 && rnd[23]) begin
      e_f = 12'sd1;
    end
    if (e_f >= 12'sd255) res = {s1, 8'hFF, 23'd0};
    else res = {s1, e_f[7:0], rnd[22:0]};
    if (spec1) res = spec_val1;
  end

  always_ff @(posedge clk) begin
    y <= res;
  end
endmodule
`default_nettype wire

### sv/qwdp_fadd.sv
// FP32 adder, round to nearest even, subnormals, canonical NaN.
// Two register stages: align, then add, normalize and round. Uses qwdp_pkg.
`default_nettype none
module qwdp_fadd
  import qwdp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic [31:0]      y
);
  logic [31:0] big, sml;
  logic [7:0]  eb, es;
  logic [8:0]  d;
  logic [26:0] mb, ms, msh;
  logic        a_nan, b_nan, a_inf, b_inf;

  always_comb begin
    if (a[30:0] >= b[30:0]) begin big = a; sml = b; end
    else begin big = b; sml = a; end
    eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    mb = {big[30:23] != 8'd0, big[22:0], 3'd0};
    ms = {sml[30:23] != 8'd0, sml[22:0], 3'd0};
    d  = 9'(eb) - 9'(es);
    if (d >= 9'd27) msh = {26'd0, ms != 27'd0};
    else msh = (ms >> d) | 27'(((ms << (9'd27 - d)) & 27'h7FF_FFFF) != 27'd0);
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
  end

  logic        s1, sub1, spec1, zsgn1;
  logic [31:0] spec_val1;
  logic [7:0]  e1;
  logic [26:0] m1, n1;

  always_ff @(posedge clk) begin
    s1   <= big[31];
    sub1 <= a[31] ^ b[31];
    e1   <= eb;
    m1   <= mb;
    n1   <= msh;
    zsgn1 <= a[31] & b[31];
    spec1 <= a_nan || b_nan || a_inf || b_inf;
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31])))
      spec_val1 <= CanonNan;
    else if (a_inf)
      spec_val1 <= a;
    else
      spec_val1 <= b;
  end

  logic [27:0] sum;
  logic [4:0]  lz;
  logic signed [9:0] e_n;
  logic [27:0] nm;
  logic [23:0] mant;
  logic        g, st;
  logic [24:0] rnd;
  logic signed [9:0] e_f;
  logic [31:0] res;
  int sh;

  always_comb begin
    sum = sub1 ? ({1'b0, m1} - {1'b0, n1}) : ({1'b0, m1} + {1'b0, n1});
    lz = 5'd0;
    for (int i = 0; i < 28; i++) begin
      if (sum[i]) lz = 5'(27 - i);
    end
    // value = sum * 2^(e1-127-26); leading one at bit 27 -> exponent e1+1-lz
    e_n = 10'(e1) + 10'sd1 - 10'(lz);
    if (e_n >= 10'sd1) sh = int'(lz);
    else sh = int'(lz) + int'(e_n) - 1;
    nm = sum << sh;
    mant = nm[27:4];
    g  = nm[3];
    st = nm[2:0] != 3'd0;
    rnd = {1'b0, mant} + 25'(g && (st || mant[0]));
    e_f = (e_n >= 10'sd1) ? e_n : 10'sd0;
    if (rnd[24]) begin
      e_f = e_f + 10'sd1;
      rnd = rnd >> 1;
    end else if (e_f == 10'sd0 && rnd[23]) begin
      e_f = 10'sd1;
    end
    if (sum == 28'd0) res = {sub1 ? 1'b0 : zsgn1, 31'd0};
    else if (e_f >= 10'sd255) res = {s1, 8'hFF, 23'd0};
    else res = {s1, e_f[7:0], rnd[22:0]};
    if (spec1) res = spec_val1;
  end

  always_ff @(posedge clk) begin
    y <= res;
  end
endmodule
`default_nettype wire

### sv/qwdp_front.sv
// Front end: accepts items, extracts the quantized value, converts the scale.
// Pushes classified work into a short queue. Uses qwdp_pkg.
`default_nettype none
module qwdp_front
  import qwdp_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     quant_mode,
  input  wire logic     in_valid,
  input  wire in_item_t in_item,
  output logic          in_stall,
  input  wire logic     pop,
  output logic          q_valid,
  output work_t         q_head
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  work_t mem [Depth];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;
  logic          push;
  logic signed [8:0] qv;
  work_t w;

  always_comb begin
    if (quant_mode) qv = 9'(signed'(in_item.weight_byte));
    else if (in_item.nibble_select) qv = 9'(in_item.weight_byte[7:4]) - 9'sd8;
    else qv = 9'(in_item.weight_byte[3:0]) - 9'sd8;
    w.qval    = int_to_single(qv);
    w.scale   = half_to_single(in_item.scale_half);
    w.act     = in_item.activation_bits;
    w.row_end = in_item.row_end;
  end

  assign in_stall = (cnt == (AW+1)'(Depth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = cnt != '0;
  assign q_head   = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= w;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= (wp == AW'(Depth - 1)) ? '0 : wp + 1'b1;
      if (pop)  rp <= (rp == AW'(Depth - 1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

### sv/qwdp_back.sv
// Back end: dequantize multiply, activation multiply, accumulate, output register.
// Sequencer around one shared multiplier and one adder. Uses qwdp_pkg, qwdp_fmul, qwdp_fadd.
`default_nettype none
module qwdp_back
  import qwdp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  input  wire work_t q_head,
  output logic       pop,
  output logic       out_valid,
  output out_item_t  out_item,
  input  wire logic  out_stall
);
  back_state_t state, state_next;
  logic [1:0]  cnt, cnt_next;
  work_t       cur;
  logic [31:0] wval, prod, acc;
  logic [31:0] ma, mb, my, ay;
  logic        load, out_load;

  qwdp_fmul u_mul (.clk(clk), .a(ma), .b(mb), .y(my));
  qwdp_fadd u_add (.clk(clk), .a(acc), .b(prod), .y(ay));

  always_comb begin
    ma = (state == ST_MUL_W) ? cur.qval : wval;
    mb = (state == ST_MUL_W) ? cur.scale : cur.act;
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt + 2'd1;
    pop        = 1'b0;
    load       = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (q_valid) begin
          pop = 1'b1; load = 1'b1; state_next = ST_MUL_W;
        end
      end
      ST_MUL_W: if (cnt == 2'd2) begin state_next = ST_MUL_P; cnt_next = '0; end
      ST_MUL_P: if (cnt == 2'd2) begin state_next = ST_ADD; cnt_next = '0; end
      ST_ADD: if (cnt == 2'd2) begin state_next = ST_OUT; cnt_next = '0; end
      ST_OUT: begin
        cnt_next = '0;
        if (!out_valid || !out_stall) begin
          out_load = 1'b1; state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) cur <= q_head;
    if (state == ST_MUL_W && cnt == 2'd2) wval <= my;
    if (state == ST_MUL_P && cnt == 2'd2) prod <= my;
    if (out_load) begin
      out_item.weight_value <= wval;
      out_item.row_sum      <= cur.row_end ? ay : 32'd0;
      out_item.row_done     <= cur.row_end;
    end
    if (rst) begin
      state <= ST_IDLE; cnt <= '0; out_valid <= 1'b0; acc <= 32'd0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (out_load) begin
        out_valid <= 1'b1;
        acc <= cur.row_end ? 32'd0 : ay;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

### sv/quantized_weight_dot_product.sv
// Quantized weight dot product: Q4_0/Q8_0 dequantize and FP32 row accumulate.
// Items are handled one at a time: a new item is popped only after the previous
// one is loaded into the output register, as the shared two-stage multiplier is used
// twice and the adder feeds the loop-carried accumulator. Synchronous reset clears
// queue, sequencer, accumulator (positive zero) and quant_mode (4-bit mode).
`default_nettype none
module quantized_weight_dot_product
  import qwdp_pkg::*;
#(
  parameter int Depth = QueueDepth
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_data,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);
  logic  quant_mode, pop, q_valid;
  work_t q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) quant_mode <= 1'b0;
    else if (cfg_valid) quant_mode <= cfg_data;
  end

  qwdp_front #(.Depth(Depth)) u_front (
    .clk, .rst, .quant_mode, .in_valid, .in_item, .in_stall,
    .pop, .q_valid, .q_head
  );

  qwdp_back u_back (
    .clk, .rst, .q_valid, .q_head, .pop, .out_valid, .out_item, .out_stall
  );
endmodule
`default_nettype wire
